// ===== rtl/emcdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emcdf_pkg
// shared constants, codes and types of the environment map cdf builder
// ----------------------------------------------------------------------------
package emcdf_pkg;

  localparam int MaxWidth    = 1024;
  localparam int MaxHeight   = 512;
  localparam int FracBits    = 16;
  localparam int ColBits     = $clog2(MaxWidth);
  localparam int RowBits     = $clog2(MaxHeight);
  localparam int WBits       = ColBits + 1;
  localparam int HBits       = RowBits + 1;
  localparam int RowSumBits  = 34;
  localparam int MapSumBits  = 43;
  localparam int CdfBits     = FracBits + 1;
  localparam int CondAddrBits = ColBits + RowBits;
  localparam int WShift      = 40 - FracBits;

  localparam logic [15:0] LumR = 16'd13933;
  localparam logic [15:0] LumG = 16'd46871;
  localparam logic [15:0] LumB = 16'd4732;

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_PIXEL   = 2'd1,
    CMD_COND    = 2'd2,
    CMD_MARG    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_QUERY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PIX,
    S_READ,
    S_DIV,
    S_DONE
  } state_t;

  // divider request from control to the shared divide unit
  typedef struct packed {
    logic                  go;
    logic [MapSumBits-1:0] num;
    logic [MapSumBits-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [CdfBits-1:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/emcdf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emcdf_div
// restoring divider, one quotient bit per cycle, rounded to nearest
// ----------------------------------------------------------------------------
module emcdf_div
  import emcdf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CntBits = $clog2(FracBits + 2);

  logic [MapSumBits:0]   rem_r, rem_nxt;
  logic [MapSumBits-1:0] den_r, den_nxt;
  logic [CdfBits-1:0]    quo_r, quo_nxt;
  logic [CntBits-1:0]    cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [MapSumBits:0]   sh;
  logic [MapSumBits:0]   dext;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dext     = {1'b0, den_r};
    sh       = {rem_r[MapSumBits-1:0], 1'b0};
    if (req.go) begin
      den_nxt  = req.den;
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      if (req.num >= req.den) begin
        rem_nxt = {1'b0, req.num - req.den};
        quo_nxt = CdfBits'(1);
      end else begin
        rem_nxt = {1'b0, req.num};
        quo_nxt = '0;
      end
    end else if (busy_r) begin
      if (cnt_r == CntBits'(FracBits)) begin
        // final rounding: r >= d - r
        if (rem_r >= (dext - rem_r)) quo_nxt = quo_r + CdfBits'(1);
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (sh >= dext) begin
          rem_nxt = sh - dext;
          quo_nxt = {quo_r[CdfBits-2:0], 1'b1};
        end else begin
          rem_nxt = sh;
          quo_nxt = {quo_r[CdfBits-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.go) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without work");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !$past(req.go) |-> rem_r < {1'b0, den_r})
    else $error("divider remainder out of range");
`endif

endmodule

// ===== rtl/emcdf_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emcdf_store
// prefix, row total and marginal prefix memories, registered read data
// ----------------------------------------------------------------------------
module emcdf_store
  import emcdf_pkg::*;
(
  input  logic                    clk,
  input  logic                    cond_we,
  input  logic [CondAddrBits-1:0] cond_waddr,
  input  logic [RowSumBits-1:0]   cond_wdata,
  input  logic                    row_we,
  input  logic [RowBits-1:0]      row_waddr,
  input  logic [RowSumBits-1:0]   tot_wdata,
  input  logic [MapSumBits-1:0]   marg_wdata,
  input  logic [CondAddrBits-1:0] cond_raddr,
  input  logic [RowBits-1:0]      row_raddr,
  output logic [RowSumBits-1:0]   cond_rdata,
  output logic [RowSumBits-1:0]   tot_rdata,
  output logic [MapSumBits-1:0]   marg_rdata
);

  logic [RowSumBits-1:0] cond_mem [MaxWidth*MaxHeight];
  logic [RowSumBits-1:0] tot_mem  [MaxHeight];
  logic [MapSumBits-1:0] marg_mem [MaxHeight];

  always_ff @(posedge clk) begin
    if (cond_we) cond_mem[cond_waddr] <= cond_wdata;
    cond_rdata <= cond_mem[cond_raddr];
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      tot_mem[row_waddr]  <= tot_wdata;
      marg_mem[row_waddr] <= marg_wdata;
    end
    tot_rdata  <= tot_mem[row_raddr];
    marg_rdata <= marg_mem[row_raddr];
  end

endmodule

// ===== rtl/env_map_cdf_builder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// env_map_cdf_builder_unit
// builds conditional and marginal cdf tables of an environment map
// ----------------------------------------------------------------------------
// Requests are taken when start is high and busy is low; each request gives
// exactly one result, shown for one cycle with out_valid, and the receiver
// cannot stall it. A restart is answered straight from the read state; a
// pixel passes the luminance multiply, the weight multiply, then the
// accumulate and memory write; a query passes the memory read, the divide
// launch register, a divider load that takes the integer quotient bit, 16
// fraction bits at one per cycle, a rounding step and the result register.
// Only one request is in flight at a time; the next one can be accepted in
// the cycle that shows the result. The stores come up undefined and need no
// clearing pass; every read follows a complete load.
// Writing a configuration register restarts the load.
module env_map_cdf_builder_unit
  import emcdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_command,
  input  logic [15:0]           in_red,
  input  logic [15:0]           in_green,
  input  logic [15:0]           in_blue,
  input  logic [16:0]           in_row_weight,
  input  logic [8:0]            in_query_row,
  input  logic [9:0]            in_query_col,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [10:0]           cfg_data,
  output logic                  out_valid,
  output logic [16:0]           out_cdf_value,
  output logic [42:0]           out_integral,
  output logic [1:0]            out_status
);

  state_t state_r, state_nxt;

  // configuration, clamped on write
  logic [WBits-1:0] width_r;
  logic [HBits-1:0] height_r;

  // load progress
  logic [ColBits-1:0]    col_r, col_nxt;
  logic [HBits-1:0]      row_r, row_nxt;
  logic [RowSumBits-1:0] row_sum_r, row_sum_nxt;
  logic [MapSumBits-1:0] map_sum_r, map_sum_nxt;
  logic                  complete_r, complete_nxt;

  // request capture
  cmd_t             cmd_r;
  logic [15:0]      red_r, green_r, blue_r;
  logic [16:0]      wgt_r;
  logic [RowBits-1:0] qrow_r;
  logic [ColBits-1:0] qcol_r;
  logic             pix_stage_r;

  // pixel arithmetic pipeline
  logic [33:0]      lum_r;
  logic [16:0]      wsat;
  logic [50:0]      prod;
  logic [RowSumBits-1:0] wpix;

  // result
  logic             valid_r, valid_nxt;
  logic [CdfBits-1:0] cdf_r, cdf_nxt;
  status_t          status_r, status_nxt;

  // memory ports
  logic                    cond_we, row_we;
  logic [RowSumBits-1:0]   cond_rdata, tot_rdata;
  logic [MapSumBits-1:0]   marg_rdata;
  logic [RowSumBits-1:0]   new_row_sum;
  logic [MapSumBits-1:0]   new_map_sum;
  logic                    row_end;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // clamp helpers for configuration writes
  logic [WBits-1:0] wclamp;
  logic [HBits-1:0] hclamp;
  always_comb begin
    wclamp = cfg_data[WBits-1:0];
    if (wclamp == '0) wclamp = WBits'(1);
    else if (wclamp > WBits'(MaxWidth)) wclamp = WBits'(MaxWidth);
    hclamp = cfg_data[HBits-1:0];
    if (hclamp == '0) hclamp = HBits'(1);
    else if (hclamp > HBits'(MaxHeight)) hclamp = HBits'(MaxHeight);
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= cmd_t'(in_command);
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
      wgt_r   <= in_row_weight;
      qrow_r  <= in_query_row;
      qcol_r  <= in_query_col;
    end
    // first multiply: luminance in q8.24
    lum_r <= 34'(LumR) * 34'(red_r) + 34'(LumG) * 34'(green_r) +
             34'(LumB) * 34'(blue_r);
  end

  // second multiply, registered result feeds accumulate
  assign wsat = (wgt_r > 17'd65536) ? 17'd65536 : wgt_r;
  always_ff @(posedge clk) begin
    prod <= 51'(lum_r) * 51'(wsat);
  end
  assign wpix = RowSumBits'((prod + 51'(1) * (51'(1) << (WShift - 1))) >> WShift);

  assign new_row_sum = row_sum_r + wpix;
  assign new_map_sum = map_sum_r + MapSumBits'(new_row_sum);
  assign row_end     = ({1'b0, col_r} + WBits'(1)) >= width_r;

  emcdf_store u_store (
    .clk        (clk),
    .cond_we    (cond_we),
    .cond_waddr ({row_r[RowBits-1:0], col_r}),
    .cond_wdata (new_row_sum),
    .row_we     (row_we),
    .row_waddr  (row_r[RowBits-1:0]),
    .tot_wdata  (new_row_sum),
    .marg_wdata (new_map_sum),
    .cond_raddr ({qrow_r, qcol_r}),
    .row_raddr  (qrow_r),
    .cond_rdata (cond_rdata),
    .tot_rdata  (tot_rdata),
    .marg_rdata (marg_rdata)
  );

  emcdf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // next state, load bookkeeping and result
  always_comb begin
    logic qbad;
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    row_sum_nxt  = row_sum_r;
    map_sum_nxt  = map_sum_r;
    complete_nxt = complete_r;
    valid_nxt    = 1'b0;
    cdf_nxt      = cdf_r;
    status_nxt   = status_r;
    cond_we      = 1'b0;
    row_we       = 1'b0;
    qbad = !complete_r || ({1'b0, qrow_r} >= height_r) ||
           ((cmd_r == CMD_COND) && ({1'b0, qcol_r} >= width_r));
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_READ;
      end
      S_READ: begin
        // memories are read this cycle; decide what the request is
        unique case (cmd_r)
          CMD_RESTART: begin
            col_nxt = '0; row_nxt = '0; row_sum_nxt = '0; map_sum_nxt = '0;
            complete_nxt = 1'b0;
            cdf_nxt = '0; status_nxt = ST_OK;
            valid_nxt = 1'b1; state_nxt = S_IDLE;
          end
          CMD_PIXEL: begin
            state_nxt = S_PIX;
          end
          CMD_COND, CMD_MARG: begin
            if (qbad) begin
              cdf_nxt = '0; status_nxt = ST_QUERY;
              valid_nxt = 1'b1; state_nxt = S_IDLE;
            end else begin
              state_nxt = S_DIV;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_PIX: begin
        // wait here while the weight product is registered
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cdf_nxt = '0;
        if (complete_r || row_r >= height_r || {1'b0, col_r} >= width_r) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_OK;
          cond_we = 1'b1;
          if (row_end) begin
            row_we      = 1'b1;
            map_sum_nxt = new_map_sum;
            row_sum_nxt = '0;
            col_nxt     = '0;
            row_nxt     = row_r + HBits'(1);
            if ((row_r + HBits'(1)) >= height_r) complete_nxt = 1'b1;
          end else begin
            row_sum_nxt = new_row_sum;
            col_nxt     = col_r + ColBits'(1);
          end
        end
        valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          cdf_nxt    = div_rsp.quo;
          status_nxt = ST_OK;
          valid_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // a configuration write restarts the load
    if (cfg_we) begin
      col_nxt      = '0;
      row_nxt      = '0;
      row_sum_nxt  = '0;
      map_sum_nxt  = '0;
      complete_nxt = 1'b0;
    end
  end

  // launch the divide on the cycle the read data arrives
  logic div_launch_r;
  always_ff @(posedge clk) begin
    if (!rst_n) div_launch_r <= 1'b0;
    else div_launch_r <= (state_r == S_READ) && (state_nxt == S_DIV);
  end

  always_comb begin
    logic [MapSumBits-1:0] p, tot;
    if (cmd_r == CMD_COND) begin
      p   = MapSumBits'(cond_rdata);
      tot = MapSumBits'(tot_rdata);
    end else begin
      p   = marg_rdata;
      tot = map_sum_r;
    end
    div_req.go = div_launch_r;
    if (tot == '0 || p > tot) begin
      // uniform fallback
      if (cmd_r == CMD_COND) begin
        div_req.num = MapSumBits'(qcol_r) + MapSumBits'(1);
        div_req.den = MapSumBits'(width_r);
      end else begin
        div_req.num = MapSumBits'(qrow_r) + MapSumBits'(1);
        div_req.den = MapSumBits'(height_r);
      end
    end else begin
      div_req.num = p;
      div_req.den = tot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      width_r    <= WBits'(MaxWidth);
      height_r   <= HBits'(MaxHeight);
      col_r      <= '0;
      row_r      <= '0;
      row_sum_r  <= '0;
      map_sum_r  <= '0;
      complete_r <= 1'b0;
      valid_r    <= 1'b0;
      status_r   <= ST_OK;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      row_sum_r  <= row_sum_nxt;
      map_sum_r  <= map_sum_nxt;
      complete_r <= complete_nxt;
      valid_r    <= valid_nxt;
      status_r   <= status_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) width_r <= wclamp;
        else height_r <= hclamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    cdf_r <= cdf_nxt;
  end

  assign pix_stage_r   = (state_r == S_PIX);
  assign out_valid     = valid_r;
  assign out_cdf_value = cdf_r;
  assign out_integral  = map_sum_r;
  assign out_status    = status_r;

`ifndef NO_ASSERTIONS
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while still busy");
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("request accepted without going busy");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_r} < width_r) || complete_r || col_r == '0)
    else $error("load column past row end");
  a_pix_order: assert property (@(posedge clk) disable iff (!rst_n)
    pix_stage_r |=> state_r == S_DONE) else $error("pixel pipeline out of order");
`endif

endmodule
